// ----- src/zrle_pkg.sv -----
// Shared types and constants for the zero run-length encoder.
package zrle_pkg;

    // Width of a data word and of the zero run counter
    localparam int WORD_BITS = 32;

    // All-ones run count: a run that reaches it is closed at once
    localparam logic [WORD_BITS-1:0] COUNT_MAX = {WORD_BITS{1'b1}};

    // Zero marker that opens a run
    localparam logic [31:0] ZERO_MARKER = 32'd0;

    // Output queue depth and count width
    localparam int QUEUE_DEPTH = 2;
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] data_word;
        logic        is_final;
    } zrle_in_t;

    typedef struct packed {
        logic [31:0] code_word;
        logic        end_of_run;
        logic        end_of_vector;
    } zrle_out_t;

    // Words produced by one input word: how many, and the words in order
    typedef struct packed {
        logic [QCOUNT_BITS-1:0] count;
        zrle_out_t              first;
        zrle_out_t              second;
    } zrle_push_t;

endpackage

// ----- src/zrle_encode.sv -----
// Encoder step: run state and the words produced by one input word.
module zrle_encode
    import zrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  zrle_in_t   item,
    input  logic       take,
    output zrle_push_t push
);

    logic                 run_reg;
    logic                 run_next;
    logic [WORD_BITS-1:0] count_reg;
    logic [WORD_BITS-1:0] count_next;

    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] count_inc;
    logic                 nonzero;

    assign word      = item.data_word[WORD_BITS-1:0];
    assign nonzero   = (word != '0);
    assign count_inc = count_reg + WORD_BITS'(1);

    // Decide the emitted words and the next run state
    always_comb
    begin
        push       = '0;
        run_next   = run_reg;
        count_next = count_reg;
        if (!run_reg)
        begin
            if (nonzero)
            begin
                push.count  = QCOUNT_BITS'(1);
                push.first  = '{32'(word), 1'b1, item.is_final};
            end
            else if (item.is_final)
            begin
                // Lone zero at the end: marker, then a count of one
                push.count  = QCOUNT_BITS'(2);
                push.first  = '{ZERO_MARKER, 1'b0, 1'b0};
                push.second = '{32'd1, 1'b1, 1'b1};
            end
            else
            begin
                // Open a run
                push.count  = QCOUNT_BITS'(1);
                push.first  = '{ZERO_MARKER, 1'b1, 1'b0};
                run_next    = 1'b1;
                count_next  = WORD_BITS'(1);
            end
        end
        else
        begin
            if (nonzero)
            begin
                // Close the run: count, then the literal
                push.count  = QCOUNT_BITS'(2);
                push.first  = '{32'(count_reg), 1'b0, 1'b0};
                push.second = '{32'(word), 1'b1, item.is_final};
                run_next    = 1'b0;
                count_next  = '0;
            end
            else if (item.is_final || count_inc == COUNT_MAX)
            begin
                // Close the run on the last word or on a full counter
                push.count  = QCOUNT_BITS'(1);
                push.first  = '{32'(count_inc), 1'b1, item.is_final};
                run_next    = 1'b0;
                count_next  = '0;
            end
            else
            begin
                count_next  = count_inc;
            end
        end
        // Start the next vector from a clean state
        if (item.is_final)
        begin
            run_next   = 1'b0;
            count_next = '0;
        end
    end

    // Advance run state on each taken word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (take)
        begin
            run_reg   <= run_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/zero_run_length_encoder_top.sv -----
// Top level of the zero run-length encoder: input register, encoder, output queue.
// An accepted word is held in an input register and encoded once the output queue
// has room for its results. Its results are written into a two-entry output queue
// whose head drives out_data, so the first result passes through the input register
// and the queue before it can leave. Some words produce at most one result: a nonzero
// word outside a run, and a zero that opens, extends or closes a run. A new such word
// is accepted every cycle while out_ready stays high. Other words produce two results:
// a nonzero word that ends a run gives a count and then the literal, and a lone zero
// as the last element gives a marker and then a count of one. The two results leave
// one after the other through the single output port, and the next word can be taken
// while the second waits. A zero that extends an open run produces no output word.
module zero_run_length_encoder_top
    import zrle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  zrle_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output zrle_out_t out_data
);

    logic                   hold_valid_reg;
    zrle_in_t               hold_item_reg;
    zrle_out_t              slot0_reg;
    zrle_out_t              slot1_reg;
    zrle_out_t              slot0_next;
    zrle_out_t              slot1_next;
    logic [QCOUNT_BITS-1:0] qcount_reg;
    logic [QCOUNT_BITS-1:0] qcount_next;
    logic [QCOUNT_BITS-1:0] remain;
    logic                   pop;
    logic                   take;
    zrle_push_t             push;

    zrle_encode u_encode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (hold_item_reg),
        .take  (take),
        .push  (push)
    );

    // Queue words left once the head word leaves this cycle
    assign pop       = out_valid && out_ready;
    assign remain    = qcount_reg - QCOUNT_BITS'(pop);
    assign take      = hold_valid_reg &&
                       (({1'b0, remain} + {1'b0, push.count}) <=
                        (QCOUNT_BITS+1)'(QUEUE_DEPTH));
    assign in_ready  = !hold_valid_reg || take;
    assign out_valid = (qcount_reg != '0);
    assign out_data  = slot0_reg;

    // Hold the accepted word until the encoder takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_item_reg <= in_data;
        end
    end

    // Shift out the head, then append the new words behind what remains
    always_comb
    begin
        zrle_out_t rest;
        rest        = pop ? slot1_reg : slot0_reg;
        slot0_next  = rest;
        slot1_next  = slot1_reg;
        qcount_next = remain;
        if (take)
        begin
            qcount_next = remain + push.count;
            if (remain == '0)
            begin
                slot0_next = push.first;
                slot1_next = push.second;
            end
            else if (remain == QCOUNT_BITS'(1))
            begin
                slot1_next = push.first;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg <= '0;
        end
        else
        begin
            qcount_reg <= qcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Queue never holds more words than it has slots
    assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= QCOUNT_BITS'(QUEUE_DEPTH))
    else $error("output queue overflow");

    // A two-word push only lands in a queue that is empty after the pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && push.count == QCOUNT_BITS'(2)) |-> (remain == '0))
    else $error("two-word push into occupied queue");

    // A waiting word that is not taken keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !take) |-> !in_ready)
    else $error("input accepted over a held word");

    // The first word of a two-word push never ends its input's results
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && push.count == QCOUNT_BITS'(2)) |-> !push.first.end_of_run)
    else $error("end of run set on first of two words");

endmodule

// ----- test/zrle_checker.sv -----
// Checker for the zero run-length encoder: predicts the output words and compares them.
`timescale 1ns / 100ps

module zrle_checker
    import zrle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  zrle_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  zrle_out_t out_data,
    output int        errors,
    output int        pending,
    output int        words_checked
);

    // Encoder state as the checker tracks it
    logic                 run_open;
    logic [WORD_BITS-1:0] run_length;

    // Output words still owed by the block, oldest first
    zrle_out_t code_words_due[$];
    int        mismatch_count = 0;

    assign errors = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void owe_word(input logic [31:0] word, input logic eor,
                                     input logic eov);
        zrle_out_t w;
        w.code_word     = word;
        w.end_of_run    = eor;
        w.end_of_vector = eov;
        code_words_due.insert(code_words_due.size(), w);
    endfunction

    // Advance the run state by one input word and queue the words it causes
    function automatic void encode_word(input zrle_in_t w);
        logic [WORD_BITS-1:0] d;
        logic                 fin;
        d   = w.data_word[WORD_BITS-1:0];
        fin = w.is_final;
        if (!run_open)
        begin
            if (d != '0)
            begin
                owe_word(d, 1'b1, fin);
            end
            else if (fin)
            begin
                // lone zero at the end: marker, then a count of one
                owe_word(ZERO_MARKER, 1'b0, 1'b0);
                owe_word(32'd1, 1'b1, 1'b1);
            end
            else
            begin
                owe_word(ZERO_MARKER, 1'b1, 1'b0);
                run_open   = 1'b1;
                run_length = WORD_BITS'(1);
            end
        end
        else if (d != '0)
        begin
            // nonzero closes the run: count, then the literal
            owe_word(run_length, 1'b0, 1'b0);
            owe_word(d, 1'b1, fin);
            run_open   = 1'b0;
            run_length = '0;
        end
        else
        begin
            run_length = run_length + WORD_BITS'(1);
            // close at the last element or when the counter saturates
            if (fin || run_length == COUNT_MAX)
            begin
                owe_word(run_length, 1'b1, fin);
                run_open   = 1'b0;
                run_length = '0;
            end
        end
        if (fin)
        begin
            run_open   = 1'b0;
            run_length = '0;
        end
    endfunction

    // Compare one accepted output word with the oldest one owed
    task automatic check_word(input zrle_out_t got);
        zrle_out_t want;
        if (code_words_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word code=%h eor=%b eov=%b",
                                      got.code_word, got.end_of_run,
                                      got.end_of_vector));
        end
        else
        begin
            want = code_words_due.pop_front();
            if (got.code_word !== want.code_word)
                report_mismatch($sformatf("code_word %h, expected %h",
                                          got.code_word, want.code_word));
            if (got.end_of_run !== want.end_of_run)
                report_mismatch($sformatf("end_of_run %b, expected %b (code %h)",
                                          got.end_of_run, want.end_of_run,
                                          want.code_word));
            if (got.end_of_vector !== want.end_of_vector)
                report_mismatch($sformatf("end_of_vector %b, expected %b (code %h)",
                                          got.end_of_vector, want.end_of_vector,
                                          want.code_word));
        end
    endtask

    // Watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open   = 1'b0;
            run_length = '0;
            code_words_due.delete();
            pending       <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_word(in_data);
            if (out_valid && out_ready)
            begin
                check_word(out_data);
                words_checked <= words_checked + 1;
            end
            pending <= code_words_due.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the zero run-length encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
    import zrle_pkg::*;
();

    localparam int QUIET_LIMIT = 4000;   // cycles with no word accepted on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off in the pressure phase
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_WORDS = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    zrle_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    zrle_out_t out_data;

    int errors;
    int pending;
    int words_checked;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int words_sent = 0;
    int vectors_sent = 0;
    int quiet_cycles = 0;

    zero_run_length_encoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    zrle_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Drive out_ready: honor a pending hold-off, else stall at random
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles, %0d words owed",
                     QUIET_LIMIT, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one input word, idling first at random, and hold it until accepted
    task automatic send_word(input logic [31:0] d, input logic fin);
        zrle_in_t w;
        w.data_word = d;
        w.is_final  = fin;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (fin)
            vectors_sent++;
    endtask

    function automatic logic [31:0] pick_nonzero();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(1, 15);
            2:       v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                              : ~(32'd1 << $urandom_range(0, 31));
        endcase
        if (v == '0)
            v = 32'd1;
        return v;
    endfunction

    // Send one vector built from zero runs and literals of random length
    task automatic send_random_vector();
        logic [31:0] words[$];
        int          segments;
        int          len;
        int          s;
        int          i;
        segments = $urandom_range(1, 6);
        for (s = 0; s < segments; s++)
        begin
            if ($urandom_range(0, 1))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 4);
                repeat (len)
                    words.insert(words.size(), 32'd0);
            end
            else
            begin
                len = $urandom_range(1, 5);
                repeat (len)
                    words.insert(words.size(), pick_nonzero());
            end
        end
        for (i = 0; i < words.size(); i++)
            send_word(words[i], (i == words.size() - 1));
    endtask

    // Run one idling pattern until enough words have gone in
    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = words_sent + n;
        while (words_sent < target)
            send_random_vector();
    endtask

    // Reset, stimulus phases, drain and verdict
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Short vectors at the edges of the run logic
        send_word(32'd0, 1'b1);
        send_word(32'd5, 1'b1);
        send_word(32'd0, 1'b0);
        send_word(32'd0, 1'b1);
        send_word(32'd0, 1'b0);
        send_word(32'd7, 1'b1);
        send_word(32'd0, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'd0, 1'b1);

        run_phase(0, 0, PHASE_WORDS);
        run_phase(87, 0, PHASE_WORDS);
        run_phase(0, 87, PHASE_WORDS);
        run_phase(38, 38, PHASE_WORDS);

        // Hold off the receiver while words keep coming, so the block backs up
        hold_left = HOLD_CYCLES;
        run_phase(0, 0, PHASE_WORDS);

        @(negedge clk);
        in_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending != 0 || out_valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Drove %0d words in %0d vectors through free-running, idle-sender,",
                 words_sent, vectors_sent);
        $display("stalled-receiver, mixed and long back-pressure patterns; %0d codes compared",
                 words_checked);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
src/zrle_pkg.sv
src/zrle_encode.sv
src/zero_run_length_encoder_top.sv
test/zrle_checker.sv
test/tb_top.sv
